/* rtl/sorted_set_engine_core_defines.svh */
// ----------------------------------------------------------------------------
// Sorted set engine assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_ENGINE_CORE_DEFINES_SVH
`define SORTED_SET_ENGINE_CORE_DEFINES_SVH

// Assert a property on an explicit clock, masked while reset is high.
`define SSE_ASSERT_AT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error(msg);

// Assert a property on the block clock clk, masked by rst.
`define SSE_ASSERT(lbl, prop, msg) `SSE_ASSERT_AT(lbl, clk, rst, prop, msg)

`endif

/* rtl/sse_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted set engine package
// Opcodes, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sse_pkg;

  localparam int SSE_CAPACITY  = 64;
  localparam int SSE_KEY_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_GET    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_MISS   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_POS_RD,
    S_POS_LATCH,
    S_DN_RD,
    S_DN_WR,
    S_FINISH
  } state_t;

endpackage

/* rtl/sorted_set_engine_core.sv */
// ----------------------------------------------------------------------------
// Sorted set engine
// Ascending set of unique keys with insert, find, delete and get.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry opcode, key and position. An item
// is taken when in_valid is high and in_stall is low. in_stall stays high
// while an item is at work and during reset.
// Output channel: out_valid / out_stall carry status, where_found, key_out
// and count, one result item per input item, from an output register.
// All work goes through one key store with a single read and a single write
// port and one key comparator, so each operation steps through the store:
//   find   : scan up from the bottom until a key is not below the searched key
//   insert : scan, then shift the keys above the slot up and write the key
//   delete : read the key at position P, then shift the keys above it down
//   get    : read the key at the position; a bad position skips the read
// A finished result sits in the output register; the engine takes the next
// item while it waits, and holds the following result until out_stall drops.
// Reset empties the set at once (count zero); entries are not cleared and are
// never read before written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_set_engine_core #(
  parameter int CAPACITY  = sse_pkg::SSE_CAPACITY,
  parameter int KEY_WIDTH = sse_pkg::SSE_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [5:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  where_found,
  output logic [31:0] key_out,
  output logic [6:0]  count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  sse_pkg::state_t  state, state_next;
  sse_pkg::opcode_t op;
  sse_pkg::opcode_t op_in;

  logic [KEY_WIDTH-1:0] key_r;
  logic [5:0]           pos_r;
  logic [CW-1:0]        key_count, count_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CW-1:0]        ptr, ptr_next;

  sse_pkg::status_t     res_status, res_status_next;
  logic [5:0]           res_where, res_where_next;
  logic [KEY_WIDTH-1:0] res_key, res_key_next;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_data, rd_data;

  logic accept, out_free;
  logic cmp_lt, cmp_eq;
  logic scan_end, scan_miss, store_full, pos_bad;
  sse_pkg::state_t miss_target;

  assign op_in    = sse_pkg::opcode_t'(opcode);
  assign in_stall = rst || (state != sse_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // shared comparator: stored key against the item key
  assign cmp_lt = rd_data < key_r;
  assign cmp_eq = rd_data == key_r;

  assign scan_end   = idx >= key_count;
  assign store_full = key_count >= CW'(CAPACITY);
  assign pos_bad    = 32'(position) >= 32'(key_count);
  assign scan_miss  = ((state == sse_pkg::S_SCAN_RD) && scan_end) ||
                      ((state == sse_pkg::S_SCAN_CMP) && !cmp_lt && !cmp_eq);
  assign miss_target = ((op == sse_pkg::OP_INSERT) && !store_full) ?
                       sse_pkg::S_UP_RD : sse_pkg::S_FINISH;

  sse_key_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      sse_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (op_in) inside
            sse_pkg::OP_INSERT, sse_pkg::OP_FIND: state_next = sse_pkg::S_SCAN_RD;
            sse_pkg::OP_DELETE, sse_pkg::OP_GET: begin
              state_next = pos_bad ? sse_pkg::S_FINISH : sse_pkg::S_POS_RD;
            end
            default: state_next = sse_pkg::S_IDLE;
          endcase
        end
      end
      sse_pkg::S_SCAN_RD: begin
        state_next = scan_end ? miss_target : sse_pkg::S_SCAN_CMP;
      end
      sse_pkg::S_SCAN_CMP: begin
        if (cmp_lt) begin
          state_next = sse_pkg::S_SCAN_RD;
        end else if (cmp_eq) begin
          state_next = sse_pkg::S_FINISH;
        end else begin
          state_next = miss_target;
        end
      end
      sse_pkg::S_UP_RD: begin
        state_next = (ptr > idx) ? sse_pkg::S_UP_WR : sse_pkg::S_INS_WR;
      end
      sse_pkg::S_UP_WR:  state_next = sse_pkg::S_UP_RD;
      sse_pkg::S_INS_WR: state_next = sse_pkg::S_FINISH;
      sse_pkg::S_POS_RD: state_next = sse_pkg::S_POS_LATCH;
      sse_pkg::S_POS_LATCH: begin
        state_next = (op == sse_pkg::OP_GET) ? sse_pkg::S_FINISH : sse_pkg::S_DN_RD;
      end
      sse_pkg::S_DN_RD: begin
        state_next = (ptr + 1'b1 < key_count) ? sse_pkg::S_DN_WR : sse_pkg::S_FINISH;
      end
      sse_pkg::S_DN_WR:  state_next = sse_pkg::S_DN_RD;
      sse_pkg::S_FINISH: state_next = out_free ? sse_pkg::S_IDLE : sse_pkg::S_FINISH;
      default:           state_next = sse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = idx[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = ptr[AW-1:0];
    wr_data         = rd_data;
    idx_next        = idx;
    ptr_next        = ptr;
    count_next      = key_count;
    res_status_next = res_status;
    res_where_next  = res_where;
    res_key_next    = res_key;
    unique case (state)
      sse_pkg::S_IDLE: begin
        idx_next        = '0;
        ptr_next        = CW'(position);
        res_status_next = sse_pkg::ST_BADPOS;
        res_where_next  = '0;
        res_key_next    = '0;
      end
      sse_pkg::S_SCAN_RD: begin
        rd_en = !scan_end;
      end
      sse_pkg::S_SCAN_CMP: begin
        if (cmp_lt) begin
          idx_next = idx + 1'b1;
        end else if (cmp_eq) begin
          res_status_next = (op == sse_pkg::OP_INSERT) ? sse_pkg::ST_DUP : sse_pkg::ST_OK;
          res_where_next  = 6'(idx);
          res_key_next    = key_r;
        end
      end
      sse_pkg::S_UP_RD: begin
        rd_en   = ptr > idx;
        rd_addr = AW'(ptr - 1'b1);
      end
      sse_pkg::S_UP_WR: begin
        // move one key up to open the slot
        wr_en    = 1'b1;
        ptr_next = ptr - 1'b1;
      end
      sse_pkg::S_INS_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx[AW-1:0];
        wr_data    = key_r;
        count_next = key_count + 1'b1;
      end
      sse_pkg::S_POS_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr[AW-1:0];
      end
      sse_pkg::S_POS_LATCH: begin
        res_status_next = sse_pkg::ST_OK;
        res_where_next  = pos_r;
        res_key_next    = rd_data;
      end
      sse_pkg::S_DN_RD: begin
        if (ptr + 1'b1 < key_count) begin
          rd_en   = 1'b1;
          rd_addr = AW'(ptr + 1'b1);
        end else begin
          count_next = key_count - 1'b1;
        end
      end
      sse_pkg::S_DN_WR: begin
        // close the gap one key at a time
        wr_en    = 1'b1;
        ptr_next = ptr + 1'b1;
      end
      sse_pkg::S_FINISH: begin
      end
      default: begin
      end
    endcase

    if (scan_miss) begin
      res_key_next   = key_r;
      res_where_next = '0;
      if (op == sse_pkg::OP_FIND) begin
        res_status_next = sse_pkg::ST_MISS;
      end else if (store_full) begin
        res_status_next = sse_pkg::ST_FULL;
      end else begin
        res_status_next = sse_pkg::ST_OK;
        res_where_next  = 6'(idx);
        ptr_next        = key_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sse_pkg::S_IDLE;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      key_count <= count_next;
      if ((state == sse_pkg::S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_where  <= res_where_next;
    res_key    <= res_key_next;
    if (accept) begin
      op    <= op_in;
      key_r <= KEY_WIDTH'(key);
      pos_r <= position;
    end
    if ((state == sse_pkg::S_FINISH) && out_free) begin
      status      <= res_status;
      where_found <= res_where;
      key_out     <= 32'(res_key);
      count       <= 7'(key_count);
    end
  end

endmodule

/* rtl/sse_key_ram.sv */
// ----------------------------------------------------------------------------
// Sorted set key store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sse_key_ram #(
  parameter int DEPTH = sse_pkg::SSE_CAPACITY,
  parameter int WIDTH = sse_pkg::SSE_KEY_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sse_checker.sv */
// ----------------------------------------------------------------------------
// Sorted set engine port checker
// Watches the top-level ports and flags handshake or result slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_set_engine_core_defines.svh"

module sse_checker #(
  parameter int CAPACITY = sse_pkg::SSE_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  opcode,
  input logic [31:0] key,
  input logic [5:0]  position,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [5:0]  where_found,
  input logic [31:0] key_out,
  input logic [6:0]  count
);

  `SSE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(where_found) && $stable(key_out) && $stable(count), "stalled result item changed")
  `SSE_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "engine took a second item while busy")
  `SSE_ASSERT(a_badpos_zero, out_valid && (status == sse_pkg::ST_BADPOS) |-> (where_found == 6'd0) && (key_out == 32'd0), "bad position result carries data")
  `SSE_ASSERT(a_full_count, out_valid && (status == sse_pkg::ST_FULL) |-> count == 7'(CAPACITY), "store full reported below capacity")

endmodule

bind sorted_set_engine_core sse_checker #(.CAPACITY(CAPACITY)) u_sse_checker (.*);
